// ----- hw/rtl/nrn_pkg.sv -----
// shared types and constants for the nth root newton block
package nrn_pkg;

  localparam int unsigned MAX_ORDER  = 15;
  localparam int unsigned VALUE_BITS = 24;
  localparam int unsigned ORDER_BITS = 4;

  localparam logic [31:0] TOLERANCE_RESET = 32'd42950;
  localparam logic [15:0] MAX_ITER_RESET  = 16'd10000;
  localparam logic [63:0] ONE_Q32         = 64'h0000_0001_0000_0000;

  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_MAX_ITER  = 1'b1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [ORDER_BITS-1:0] order;
  } item_t;

  typedef struct packed {
    logic [31:0] root;
    logic        converged;
    logic [15:0] steps_used;
  } result_t;

  typedef enum logic {
    DIV_SEL_K,
    DIV_SEL_N
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POW_INIT,
    ST_POW,
    ST_MUL,
    ST_ZERO,
    ST_DIV_K,
    ST_DIV_N_START,
    ST_DIV_N,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     pow_init;
    logic     mul_start;
    logic     p_take;
    logic     div_start;
    div_sel_t div_sel;
    logic     t_take;
    logic     g_take;
    logic     update;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic e_lt;
    logic mul_done;
    logic p_zero;
    logic div_done;
    logic stop;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/nrn_mul.sv -----
// saturating q32.32 multiplier, one 32x32 partial product per cycle
module nrn_mul import nrn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] y
);

  logic        busy;
  logic        iss;
  logic        pv;
  logic [1:0]  idx;
  logic [1:0]  pidx;
  logic [63:0] prod;
  logic [63:0] acc;
  logic        sat;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [63:0] term;
  logic        ovf;
  logic [64:0] sum;

  always_comb begin
    case (idx)
      2'd0: begin
        opa = a[63:32];
        opb = b[63:32];
      end
      2'd1: begin
        opa = a[63:32];
        opb = b[31:0];
      end
      2'd2: begin
        opa = a[31:0];
        opb = b[63:32];
      end
      default: begin
        opa = a[31:0];
        opb = b[31:0];
      end
    endcase
  end

  always_comb begin
    ovf = 1'b0;
    case (pidx)
      2'd0: begin
        term = {prod[31:0], 32'b0};
        ovf  = |prod[63:32];
      end
      2'd3: term = {32'b0, prod[63:32]};
      default: term = prod;
    endcase
    sum = {1'b0, acc} + {1'b0, term};
  end

  always_ff @(posedge clk) begin
    if (iss) begin
      prod <= {32'b0, opa} * {32'b0, opb};
      pidx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iss  <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iss  <= 1'b1;
        pv   <= 1'b0;
        idx  <= 2'd0;
        acc  <= 64'b0;
        sat  <= 1'b0;
      end else if (busy) begin
        pv <= iss;
        if (iss) begin
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            iss <= 1'b0;
          end
        end
        if (pv) begin
          acc <= sum[63:0];
          sat <= sat | ovf | sum[64];
          if (pidx == 2'd3) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign y = sat ? '1 : acc;

endmodule

// ----- hw/rtl/nrn_div.sv -----
// restoring divider, one quotient bit per cycle, saturating quotient
module nrn_div import nrn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] q
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] num;
  logic [64:0] shifted;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    shifted = {rem, num[63]};
    diff    = shifted - {1'b0, den};
    ge      = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (hi >= den) begin
          q    <= '1;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem  <= hi;
          num  <= lo;
          q    <= 64'b0;
          cnt  <= 6'd0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        num <= {num[62:0], 1'b0};
        q   <= {q[62:0], ge};
        rem <= ge ? diff[63:0] : shifted[63:0];
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/nrn_datapath.sv -----
// newton step datapath: guesses, power, quotients and result register
module nrn_datapath import nrn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  item_t       item,
  input  logic [31:0] tolerance,
  input  logic [15:0] max_iterations,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  logic [VALUE_BITS-1:0] k;
  logic [ORDER_BITS-1:0] n;
  logic [ORDER_BITS-1:0] m;
  logic [ORDER_BITS-1:0] e;
  logic [63:0] old_g;
  logic [63:0] new_g;
  logic [63:0] p;
  logic [63:0] t;
  logic [15:0] steps;
  logic        conv;

  logic [63:0] mul_y;
  logic        mul_done;
  logic [63:0] div_hi;
  logic [63:0] div_lo;
  logic [63:0] div_den;
  logic [63:0] div_q;
  logic        div_done;

  logic [67:0] mprod;
  logic [63:0] mt;
  logic [64:0] tsum;
  logic [63:0] dg;
  logic        below;
  logic [15:0] limit;
  logic [15:0] steps_inc;
  logic [ORDER_BITS-1:0] n_in;
  result_t     fmt;

  assign m = n - 4'd1;

  always_comb begin
    n_in = ({2'b0, item.order} > 6'(MAX_ORDER)) ? ORDER_BITS'(MAX_ORDER) : item.order;
    mprod = {4'b0, old_g} * {64'b0, m};
    mt    = (|mprod[67:64]) ? '1 : mprod[63:0];
    tsum  = {1'b0, mt} + {1'b0, div_q};
    dg    = (new_g >= old_g) ? (new_g - old_g) : (old_g - new_g);
    below = dg < {32'b0, tolerance};
    limit = (max_iterations == 16'd0) ? 16'd1 : max_iterations;
    steps_inc = steps + 16'd1;
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SEL_K: begin
        div_hi  = 64'(k);
        div_lo  = 64'b0;
        div_den = p;
      end
      DIV_SEL_N: begin
        div_hi  = 64'b0;
        div_lo  = t;
        div_den = 64'(n);
      end
      default: begin
        div_hi  = 64'b0;
        div_lo  = t;
        div_den = 64'(n);
      end
    endcase
  end

  nrn_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (p),
    .b     (old_g),
    .done  (mul_done),
    .y     (mul_y)
  );

  nrn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .hi    (div_hi),
    .lo    (div_lo),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k     <= item.value;
      n     <= n_in;
      old_g <= {32'(item.value), 32'b0};
      new_g <= ONE_Q32;
      steps <= 16'd0;
      conv  <= 1'b0;
    end
    if (cmd.pow_init) begin
      p <= old_g;
      e <= 4'd1;
    end
    if (cmd.p_take) begin
      p <= mul_y;
      e <= e + 4'd1;
    end
    if (cmd.t_take) begin
      t <= tsum[64] ? '1 : tsum[63:0];
    end
    if (cmd.g_take) begin
      new_g <= div_q;
    end
    if (cmd.update) begin
      steps <= steps_inc;
      conv  <= below;
      if (!status.stop) begin
        old_g <= new_g;
      end
    end
  end

  always_comb begin
    fmt = '0;
    if (n == 4'd1) begin
      if (VALUE_BITS > 16 && (|(k >> 16))) begin
        fmt.root = '1;
      end else begin
        fmt.root = {16'(k), 16'b0};
      end
    end else if (n != 4'd0) begin
      fmt.root       = (|new_g[63:48]) ? '1 : new_g[47:16];
      fmt.converged  = conv;
      fmt.steps_used = steps;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= fmt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    status.special  = n < 4'd2;
    status.e_lt     = e < m;
    status.mul_done = mul_done;
    status.p_zero   = p == 64'b0;
    status.div_done = div_done;
    status.stop     = below || (steps_inc >= limit);
    status.out_free = !result_valid || !result_stall;
  end

endmodule

// ----- hw/rtl/nrn_ctrl.sv -----
// sequencer for the newton iteration
module nrn_ctrl import nrn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_SEL_K;
    item_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = status.special ? ST_DONE : ST_POW_INIT;
      end
      ST_POW_INIT: begin
        cmd.pow_init = 1'b1;
        state_next   = ST_POW;
      end
      ST_POW: begin
        if (status.e_lt) begin
          cmd.mul_start = 1'b1;
          state_next    = ST_MUL;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_MUL: begin
        if (status.mul_done) begin
          cmd.p_take = 1'b1;
          state_next = ST_POW;
        end
      end
      ST_ZERO: begin
        if (status.p_zero) begin
          state_next = ST_UPDATE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV_K;
        end
      end
      ST_DIV_K: begin
        if (status.div_done) begin
          cmd.t_take = 1'b1;
          state_next = ST_DIV_N_START;
        end
      end
      ST_DIV_N_START: begin
        cmd.div_sel   = DIV_SEL_N;
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_N;
      end
      ST_DIV_N: begin
        cmd.div_sel = DIV_SEL_N;
        if (status.div_done) begin
          cmd.g_take = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.stop ? ST_DONE : ST_POW_INIT;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/nth_root_newton.sv -----
// nth root newton top level: configuration registers, controller and datapath
// orders 0 and 1 skip the newton steps; other orders run steps until the tolerance or the iteration limit is met
// each step runs n-2 products on a shared 32x32 multiplier and two divisions
// a step whose power truncates to zero skips both divisions
// one transaction is worked at a time; the next input is taken after the result is registered
// synchronous reset: tolerance 42950, max_iterations 10000, no result pending
module nth_root_newton import nrn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] tolerance;
  logic [15:0] max_iterations;
  cmd_t        cmd;
  status_t     status;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= TOLERANCE_RESET;
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tolerance      <= cfg_data;
        CFG_MAX_ITER:  max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  nrn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  nrn_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .item           (item),
    .tolerance      (tolerance),
    .max_iterations (max_iterations),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result)
  );

endmodule
